[hw/rtl/hex_char_fifo_packer_top_macros.svh]
// Assertion helpers shared by the packer RTL.
`ifndef HEX_CHAR_FIFO_PACKER_TOP_MACROS_SVH
`define HEX_CHAR_FIFO_PACKER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HCFP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hcfp: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define HCFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hcfp: next-cycle check failed");

`endif

[hw/rtl/hcfp_pkg.sv]
package hcfp_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 64;
   localparam int unsigned NUM_QUEUES_DEF  = 4;

   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned FILL_W   = 7;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned NIBBLE_W = 4;
   localparam int unsigned REM_W    = 4;

   localparam logic [REM_W-1:0] NEED_POP  = 4'd1;
   localparam logic [REM_W-1:0] NEED_BYTE = 4'd2;
   localparam logic [REM_W-1:0] NEED_WORD = 4'd8;

   localparam logic [BYTE_W-1:0] CHAR_0  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_9  = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_LA = 8'h61;
   localparam logic [BYTE_W-1:0] CHAR_LF = 8'h66;
   localparam logic [BYTE_W-1:0] CHAR_UA = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UF = 8'h46;

   typedef enum logic [1:0] {
      OP_PUSH      = 2'd0,
      OP_POP       = 2'd1,
      OP_PACK_BYTE = 2'd2,
      OP_PACK_WORD = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_READ,
      ST_DONE
   } state_type;

   // Control of the shared nibble accumulator.
   typedef struct packed {
      logic clear;
      logic load;
      logic raw;
   } acc_ctl_type;

   function automatic logic is_hex_char(input logic [BYTE_W-1:0] c);
      return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_LA && c <= CHAR_LF) ||
             (c >= CHAR_UA && c <= CHAR_UF);
   endfunction

   function automatic logic [NIBBLE_W-1:0] hex_value(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] v;
      v = '0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         v = c - CHAR_0;
      end else if (c >= CHAR_LA && c <= CHAR_LF) begin
         v = c - CHAR_LA + 8'd10;
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         v = c - CHAR_UA + 8'd10;
      end
      return v[NIBBLE_W-1:0];
   endfunction

endpackage

[hw/rtl/hcfp_ram.sv]
module hcfp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/hcfp_nibble_acc.sv]
// Shared shift unit: clears, loads a raw character or shifts in its hex nibble.
module hcfp_nibble_acc (
   input  logic                               clock,
   input  hcfp_pkg::acc_ctl_type              ctl,
   input  logic [hcfp_pkg::BYTE_W-1:0]        char_in,
   output logic [hcfp_pkg::VALUE_W-1:0]       acc_out
);

   logic [hcfp_pkg::VALUE_W-1:0] acc_ff;
   logic [hcfp_pkg::VALUE_W-1:0] acc_in;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.load) begin
         if (ctl.raw) begin
            acc_in = hcfp_pkg::VALUE_W'(char_in);
         end else begin
            acc_in = {acc_ff[hcfp_pkg::VALUE_W-hcfp_pkg::NIBBLE_W-1:0],
                      hcfp_pkg::hex_value(char_in)};
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc_out = acc_ff;

endmodule

[hw/rtl/hex_char_fifo_packer_top.sv]
// Hex character FIFO packer: one ring queue of ASCII hex characters per slave.
// Requests enter on the req_ stream channel. req_tuser carries the operation
// and the slave number, req_tdata carries the received byte (used by push).
// Each request yields exactly one response on the rsp_ channel: rsp_tdata
// holds the value and the fill level, rsp_tuser the failure flag.
// Each request passes through DECIDE, which settles a push or any short-queue
// request, then READ for a pop or pack with enough characters (a pop reads
// one, a byte pack two and a word pack eight), then DONE, which registers the
// response once the output register is free; the sequencer then returns to
// idle. The character RAM has one read port with registered data, so the
// characters are read one by one and the last read drains into the shared
// accumulator before DONE.
// Only one request is worked on at a time; req_tready is high while idle.
// The response sits in an output register, so a new request can be taken
// while an earlier response waits; if the receiver stalls, the sequencer
// holds the finished result until the output register frees up.
// Synchronous reset empties every queue (pointers and counts cleared) and
// drops any pending response; the character RAM itself is not cleared.
module hex_char_fifo_packer_top #(
   parameter int unsigned QUEUE_DEPTH = hcfp_pkg::QUEUE_DEPTH_DEF,
   parameter int unsigned NUM_QUEUES  = hcfp_pkg::NUM_QUEUES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [3:0]  req_tuser,   // [1:0] op, [3:2] slave
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] value, [38:32] fill_level, [39] zero
   output logic        rsp_tuser    // [0] failed
);

   `include "hex_char_fifo_packer_top_macros.svh"

   localparam int unsigned PW = $clog2(QUEUE_DEPTH);
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int unsigned AW = QW + PW;
   localparam int unsigned RAM_DEPTH = 1 << AW;

   // Sequencer state and latched request.
   hcfp_pkg::state_type state_ff, state_in;
   hcfp_pkg::op_type    op_ff, op_in;
   logic [QW-1:0]       q_ff, q_in;
   logic [hcfp_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic [hcfp_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic                pend_ff, pend_in;
   logic                fail_ff, fail_in;

   // Per-queue bookkeeping.
   logic [PW-1:0] rptr_ff  [NUM_QUEUES];
   logic [PW-1:0] rptr_in  [NUM_QUEUES];
   logic [PW-1:0] wptr_ff  [NUM_QUEUES];
   logic [PW-1:0] wptr_in  [NUM_QUEUES];
   logic [CW-1:0] count_ff [NUM_QUEUES];
   logic [CW-1:0] count_in [NUM_QUEUES];

   // Response register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [hcfp_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                         rsp_fail_ff, rsp_fail_in;
   logic [hcfp_pkg::FILL_W-1:0]  rsp_fill_ff, rsp_fill_in;

   logic                         req_accept;
   logic [QW-1:0]                slave_q;
   logic [CW-1:0]                cur_count;
   logic [hcfp_pkg::REM_W-1:0]   need;
   logic                         hex_ok;
   logic                         push_ok;
   logic                         push_full;
   logic                         short_q;
   logic                         go_read;
   logic                         out_free;

   logic                         ram_wr_en;
   logic [AW-1:0]                ram_wr_addr;
   logic                         ram_rd_en;
   logic [AW-1:0]                ram_rd_addr;
   logic [hcfp_pkg::BYTE_W-1:0]  ram_rd_data;

   hcfp_pkg::acc_ctl_type        acc_ctl;
   logic [hcfp_pkg::VALUE_W-1:0] acc_value;

   hcfp_ram #(
      .WIDTH (hcfp_pkg::BYTE_W),
      .DEPTH (RAM_DEPTH)
   ) u_char_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (byte_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   hcfp_nibble_acc u_acc (
      .clock   (clock),
      .ctl     (acc_ctl),
      .char_in (ram_rd_data),
      .acc_out (acc_value)
   );

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Slave numbers past the last queue wrap around; the field is only two bits,
   // so a few conditional subtractions finish the reduction.
   always_comb begin
      logic [3:0] s;
      s = {2'b00, req_tuser[3:2]};
      for (int k = 0; k < 3; k++) begin
         if (s >= 4'(NUM_QUEUES)) begin
            s = s - 4'(NUM_QUEUES);
         end
      end
      slave_q = QW'(s);
   end

   // Decision terms evaluated in the DECIDE cycle on the latched request.
   always_comb begin
      cur_count = count_ff[q_ff];
      case (op_ff)
         hcfp_pkg::OP_POP:       need = hcfp_pkg::NEED_POP;
         hcfp_pkg::OP_PACK_BYTE: need = hcfp_pkg::NEED_BYTE;
         default:                need = hcfp_pkg::NEED_WORD;
      endcase
      hex_ok    = hcfp_pkg::is_hex_char(byte_ff);
      push_ok   = (op_ff == hcfp_pkg::OP_PUSH) && hex_ok && (cur_count < CW'(QUEUE_DEPTH));
      push_full = (op_ff == hcfp_pkg::OP_PUSH) && hex_ok && !(cur_count < CW'(QUEUE_DEPTH));
      short_q   = (op_ff != hcfp_pkg::OP_PUSH) && (cur_count < CW'(need));
      go_read   = (op_ff != hcfp_pkg::OP_PUSH) && !short_q;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hcfp_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = hcfp_pkg::ST_DECIDE;
            end
         end
         hcfp_pkg::ST_DECIDE: begin
            state_in = go_read ? hcfp_pkg::ST_READ : hcfp_pkg::ST_DONE;
         end
         hcfp_pkg::ST_READ: begin
            if (rem_ff == '0) begin
               state_in = hcfp_pkg::ST_DONE;
            end
         end
         hcfp_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = hcfp_pkg::ST_IDLE;
            end
         end
         default: state_in = hcfp_pkg::ST_IDLE;
      endcase
   end

   // Outputs and datapath updates.
   always_comb begin
      req_tready   = 1'b0;
      op_in        = op_ff;
      q_in         = q_ff;
      byte_in      = byte_ff;
      rem_in       = rem_ff;
      pend_in      = 1'b0;
      fail_in      = fail_ff;
      rptr_in      = rptr_ff;
      wptr_in      = wptr_ff;
      count_in     = count_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = {q_ff, wptr_ff[q_ff]};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = {q_ff, rptr_ff[q_ff]};
      acc_ctl      = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_fail_in  = rsp_fail_ff;
      rsp_fill_in  = rsp_fill_ff;

      unique case (state_ff)
         hcfp_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_accept) begin
               op_in   = hcfp_pkg::op_type'(req_tuser[1:0]);
               q_in    = slave_q;
               byte_in = req_tdata;
            end
         end
         hcfp_pkg::ST_DECIDE: begin
            acc_ctl.clear = 1'b1;
            fail_in       = push_full || short_q;
            rem_in        = go_read ? need : '0;
            if (push_ok) begin
               ram_wr_en       = 1'b1;
               wptr_in[q_ff]   = (wptr_ff[q_ff] == PW'(QUEUE_DEPTH - 1)) ?
                                 '0 : wptr_ff[q_ff] + PW'(1);
               count_in[q_ff]  = cur_count + CW'(1);
            end
         end
         hcfp_pkg::ST_READ: begin
            // Reads are issued back to back; each returning character is folded
            // into the accumulator in the cycle after its read.
            acc_ctl.load = pend_ff;
            acc_ctl.raw  = (op_ff == hcfp_pkg::OP_POP);
            if (rem_ff != '0) begin
               ram_rd_en      = 1'b1;
               rptr_in[q_ff]  = (rptr_ff[q_ff] == PW'(QUEUE_DEPTH - 1)) ?
                                '0 : rptr_ff[q_ff] + PW'(1);
               count_in[q_ff] = cur_count - CW'(1);
               rem_in         = rem_ff - hcfp_pkg::REM_W'(1);
               pend_in        = 1'b1;
            end
         end
         hcfp_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = acc_value;
               rsp_fail_in  = fail_ff;
               rsp_fill_in  = hcfp_pkg::FILL_W'(cur_count);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hcfp_pkg::ST_IDLE;
         rem_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            rptr_ff[i]  <= '0;
            wptr_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rem_ff       <= rem_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         rptr_ff      <= rptr_in;
         wptr_ff      <= wptr_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      q_ff         <= q_in;
      byte_ff      <= byte_in;
      fail_ff      <= fail_in;
      rsp_value_ff <= rsp_value_in;
      rsp_fail_ff  <= rsp_fail_in;
      rsp_fill_ff  <= rsp_fill_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_fill_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_fail_ff;

   // A queue never holds more characters than its depth.
   `HCFP_ASSERT_IMPL(a_count_bound, clock, reset, state_ff != hcfp_pkg::ST_IDLE, count_ff[q_ff] <= CW'(QUEUE_DEPTH))
   // An accepted request always moves the sequencer into its decision cycle.
   `HCFP_ASSERT_NEXT(a_accept_decide, clock, reset, req_tvalid && req_tready, state_ff == hcfp_pkg::ST_DECIDE)
   // No reads are outstanding once the sequencer is back to idle.
   `HCFP_ASSERT_IMPL(a_idle_quiet, clock, reset, state_ff == hcfp_pkg::ST_IDLE, rem_ff == '0 && !pend_ff)
   // A failed request never reports a nonzero value.
   `HCFP_ASSERT_IMPL(a_fail_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[31:0] == '0)

endmodule
